### sv/assert_macros.svh
// Assertion macros used by the checker in rqd_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset-qualified
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-qualified
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/rqd_pkg.sv
// Shared types and constants for the ready queue dispatcher.
// No dependencies.
package rqd_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 16;
	localparam int PRI_W     = 8;
	localparam int OCC_W     = 5;
	localparam int MODE_W    = 2;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_FIFO = 2'd0;
	localparam mode_t MODE_PRIO = 2'd1;
	localparam mode_t MODE_MLQ  = 2'd2;

	localparam logic FUNC_ENQ  = 1'b0;
	localparam logic FUNC_DISP = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} entry_t;

	typedef struct packed {
		logic             granted;
		logic [ID_W-1:0]  chosen_id;
		logic [PRI_W-1:0] chosen_pri;
		logic             qstart;
		logic             ovf;
		logic [OCC_W-1:0] occ;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

endpackage

### sv/rqd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/rqd_engine.sv
// Queue sequencer: enqueue, min-priority scan (head only in FIFO mode) and compaction over the entry RAM.
// Depends on rqd_pkg; drives the ports of one rqd_ram.
module rqd_engine import rqd_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEF,
	localparam int IDX_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic             req_func,
	input  logic [ID_W-1:0]  req_id,
	input  logic [PRI_W-1:0] req_pri,
	input  mode_t            mode,
	output logic             res_valid,
	input  logic             res_take,
	output result_t          res,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output entry_t           wr_data,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	input  entry_t           rd_data
);

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_q;
	logic [CNT_W-1:0] lim_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_q;
	result_t          res_q;

	logic accept;
	logic issue;
	logic full;
	logic mode_ok;
	logic disp_work;
	logic drained;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign mode_ok   = (mode == MODE_FIFO) || (mode == MODE_PRIO) || (mode == MODE_MLQ);
	assign disp_work = (req_func == FUNC_DISP) && mode_ok && (cnt_q != '0);
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_q < lim_q);
	assign drained   = !issue && !vld_s1;
	assign accept    = req_valid && !req_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = disp_work ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (drained) begin
					state_nxt = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (drained) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs and RAM port control
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		res_valid = (state_q == ST_DONE);
		res       = res_q;
		rd_en     = issue;
		rd_addr   = rd_q[IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = idx_s1 - IDX_W'(1);
		wr_data   = rd_data;
		case (state_q)
			ST_IDLE: begin
				wr_en      = accept && (req_func == FUNC_ENQ) && !full;
				wr_addr    = cnt_q[IDX_W-1:0];
				wr_data.id  = req_id;
				wr_data.pri = req_pri;
			end
			ST_SHIFT: begin
				// entry at idx_s1 moves down one place
				wr_en = vld_s1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			vld_s1  <= issue;
			if (state_q == ST_IDLE && accept && req_func == FUNC_ENQ && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_SHIFT && drained) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IDX_W-1:0];
		if (issue) begin
			rd_q <= rd_q + CNT_W'(1);
		end
		case (state_q)
			ST_IDLE: begin
				rd_q  <= '0;
				lim_q <= (mode == MODE_FIFO) ? CNT_W'(1) : cnt_q;
				res_q.granted    <= 1'b0;
				res_q.chosen_id  <= '0;
				res_q.chosen_pri <= '0;
				res_q.qstart     <= (req_func == FUNC_DISP) && (mode == MODE_MLQ);
				res_q.ovf        <= (req_func == FUNC_ENQ) && full;
				res_q.occ        <= ((req_func == FUNC_ENQ) && !full) ?
					OCC_W'(cnt_q + CNT_W'(1)) : OCC_W'(cnt_q);
			end
			ST_SCAN: begin
				// strict compare keeps the earliest arrival on ties
				if (vld_s1 && (idx_s1 == '0 || rd_data.pri < best_q.pri)) begin
					best_q     <= rd_data;
					best_idx_q <= idx_s1;
				end
				if (drained) begin
					rd_q  <= CNT_W'(best_idx_q) + CNT_W'(1);
					lim_q <= cnt_q;
				end
			end
			ST_SHIFT: begin
				if (drained) begin
					res_q.granted    <= 1'b1;
					res_q.chosen_id  <= best_q.id;
					res_q.chosen_pri <= best_q.pri;
					res_q.qstart     <= (mode == MODE_MLQ);
					res_q.ovf        <= 1'b0;
					res_q.occ        <= OCC_W'(cnt_q - CNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### sv/ready_queue_dispatcher.sv
// Ready queue dispatcher over an entry RAM; depends on rqd_pkg, rqd_ram and rqd_engine.
// Enqueue, empty dispatch and mode-3 dispatch go straight to the response; a FIFO grant reads
// only the head, then compacts every entry behind it; a priority grant runs a full scan, then
// compacts the entries behind the chosen one. One word in flight: the next is taken only
// after the response has registered. Reset: async, queue empty, mode FIFO.
module ready_queue_dispatcher import rqd_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEF,
	localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	// mode register write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MODE_W-1:0] dispatch_mode,
	// request words
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              func,
	input  logic [ID_W-1:0]   thread_id,
	input  logic [PRI_W-1:0]  thread_priority,
	// response words
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              granted,
	output logic [ID_W-1:0]   chosen_id,
	output logic [PRI_W-1:0]  chosen_priority,
	output logic              quantum_start,
	output logic              overflow,
	output logic [OCC_W-1:0]  occupancy
);

	mode_t   mode_q;
	logic    rsp_valid_q;
	result_t out_q;

	logic             res_valid;
	logic             res_take;
	result_t          res;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;

	// mode writes only land between words
	assign cfg_ready = !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIFO;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= dispatch_mode;
		end
	end

	// entry storage: {id, priority}, compacted toward address 0
	rqd_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	rqd_engine #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_func (func),
		.req_id   (thread_id),
		.req_pri  (thread_priority),
		.mode     (mode_q),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// output register: frees the engine while a response sits stalled
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign granted         = out_q.granted;
	assign chosen_id       = out_q.chosen_id;
	assign chosen_priority = out_q.chosen_pri;
	assign quantum_start   = out_q.qstart;
	assign overflow        = out_q.ovf;
	assign occupancy       = out_q.occ;

endmodule

### sv/rqd_checker.sv
// Port-level checker for ready_queue_dispatcher, bound to the top level.
// Depends on rqd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rqd_checker import rqd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic              granted,
	input logic [ID_W-1:0]   chosen_id,
	input logic [PRI_W-1:0]  chosen_priority,
	input logic              quantum_start,
	input logic              overflow,
	input logic [OCC_W-1:0]  occupancy
);

	`ASSERT_IMP(a_no_grant_zero, clk, arst_n, rsp_valid && !granted, chosen_id == '0 && chosen_priority == '0, "chosen fields set without grant")
	`ASSERT_IMP(a_ovf_alone, clk, arst_n, rsp_valid && overflow, !granted && !quantum_start, "overflow on a dispatch word")
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(chosen_id) && $stable(occupancy), "stalled response changed")

endmodule

bind ready_queue_dispatcher rqd_checker u_rqd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.granted        (granted),
	.chosen_id      (chosen_id),
	.chosen_priority(chosen_priority),
	.quantum_start  (quantum_start),
	.overflow       (overflow),
	.occupancy      (occupancy)
);
